@@ src/bivariate_poly_eval_top_defines.svh @@
`ifndef BIVARIATE_POLY_EVAL_TOP_DEFINES_SVH
`define BIVARIATE_POLY_EVAL_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BPE_ASSERT_IMPL(lbl, pre, post) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
	else $error("bivariate_poly_eval_top: port check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BPE_ASSERT_NEXT(lbl, pre, post) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error("bivariate_poly_eval_top: port check failed");

`endif

@@ src/bpe_pkg.sv @@
package bpe_pkg;

	localparam int MAX_DEGREE = 4;
	localparam int STORE_DEPTH = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) / 2;
	localparam int PW_W = (MAX_DEGREE > 0) ? $clog2(MAX_DEGREE + 1) : 1;
	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	// 48-bit terms, plus growth for the term count
	localparam int ACC_W = 48 + AW;

	localparam int DEG_W = 3;
	localparam int IDX_W = 4;
	localparam int COEF_W = 32;
	localparam int CRD_W = 16;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
	localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7fff_ffff;
	localparam logic signed [63:0] S32_MIN = 64'shffff_ffff_8000_0000;

	typedef struct packed {
		logic clip;
		logic signed [31:0] val;
	} sat_t;

	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		if (v > S32_MAX) begin
			r.clip = 1'b1;
			r.val = S32_MAX[31:0];
		end else if (v < S32_MIN) begin
			r.clip = 1'b1;
			r.val = S32_MIN[31:0];
		end else begin
			r.clip = 1'b0;
			r.val = v[31:0];
		end
		return r;
	endfunction

endpackage

@@ src/bpe_ram.sv @@
module bpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW_L = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW_L-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [AW_L-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/bivariate_poly_eval_top.sv @@
// Bivariate polynomial evaluator, Q16.16 coefficients, Q8.8 point.
// Input channel (in_valid/in_ready): cmd selects a coefficient load
// (coef_index, coef_value) or an evaluation at (x_coord, y_coord).
// Output channel (out_valid/out_ready): one poly_value/saturated result per
// evaluation, none per load. Config channel (cfg_valid/cfg_ready, degree)
// sets the total degree; degrees above the maximum act as the maximum.
// An evaluation at degree D with T = (D+1)(D+2)/2 terms runs D power steps,
// each a multiply state and a write-back state on the x and y multipliers,
// then one term per cycle through the coefficient RAM read and the
// multiply-accumulate pipe, then drains the pipe and saturates the sum.
// The input reopens as the result appears, so a new evaluation is accepted
// only once the previous one has finished; a load leaves the input open.
// The output register holds a result until taken; loads and a new evaluation
// are accepted meanwhile, and a finished evaluation waits for the register
// to free up before the input side reopens.
// Reset sets the degree to two and empties the pipe; coefficients are not
// cleared and must be loaded before use.
module bivariate_poly_eval_top
	import bpe_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic cmd,
	input logic [IDX_W-1:0] coef_index,
	input logic signed [COEF_W-1:0] coef_value,
	input logic signed [CRD_W-1:0] x_coord,
	input logic signed [CRD_W-1:0] y_coord,
	output logic out_valid,
	input logic out_ready,
	output logic signed [31:0] poly_value,
	output logic saturated,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [DEG_W-1:0] degree
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_POW_MUL = 3'd1;
	localparam logic [2:0] ST_POW_WB = 3'd2;
	localparam logic [2:0] ST_TERM = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;

	logic [2:0] state_q;
	logic [DEG_W-1:0] deg_q;
	logic [PW_W-1:0] deg_use;
	logic [PW_W-1:0] k_q, d_q, dx_q;
	logic [PW_W-1:0] k_prev, py_idx;
	logic [AW-1:0] i_q;
	logic signed [CRD_W-1:0] x_q, y_q;
	logic signed [31:0] px_q [0:MAX_DEGREE];
	logic signed [31:0] py_q [0:MAX_DEGREE];
	logic v_s1, v_s2, v_s3;
	logic signed [63:0] prod_a_s1;
	logic signed [31:0] mono_s2, coef_s2;
	logic signed [63:0] prod_b_s3;
	logic signed [ACC_W-1:0] acc_q;
	logic clip_q;
	logic out_valid_q, saturated_q;
	logic signed [31:0] poly_value_q;

	logic accept_in, eval_go, pow_phase, last_term, pipe_empty, emit;
	logic signed [31:0] mul_a_l, mul_a_r, mul_b_l, mul_b_r;
	logic signed [63:0] mul_a, mul_b, term_sh;
	sat_t sat_px, sat_py, sat_mono, sat_res;
	logic ram_we, ram_re;
	logic [AW-1:0] ram_waddr;
	logic [COEF_W-1:0] ram_rdata;

	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept_in = in_valid && in_ready;
	assign eval_go = accept_in && (cmd == CMD_EVAL);

	always_comb begin
		if (int'(deg_q) > MAX_DEGREE) begin
			deg_use = PW_W'(MAX_DEGREE);
		end else begin
			deg_use = PW_W'(deg_q);
		end
	end

	assign k_prev = k_q - 1'b1;
	assign py_idx = d_q - dx_q;
	assign pow_phase = (state_q == ST_POW_MUL);
	assign last_term = (d_q == '0) && (dx_q == '0);
	assign pipe_empty = !v_s1 && !v_s2 && !v_s3;
	assign emit = (state_q == ST_DRAIN) && pipe_empty && (!out_valid_q || out_ready);

	// Multiplier A: x powers, then monomials. Multiplier B: y powers, then terms.
	assign mul_a_l = pow_phase ? px_q[k_prev] : px_q[dx_q];
	assign mul_a_r = pow_phase ? {{(32-CRD_W){x_q[CRD_W-1]}}, x_q} : py_q[py_idx];
	assign mul_b_l = pow_phase ? py_q[k_prev] : coef_s2;
	assign mul_b_r = pow_phase ? {{(32-CRD_W){y_q[CRD_W-1]}}, y_q} : mono_s2;
	assign mul_a = mul_a_l * mul_a_r;
	assign mul_b = mul_b_l * mul_b_r;

	assign sat_px = sat32(prod_a_s1 >>> 8);
	assign sat_py = sat32(prod_b_s3 >>> 8);
	assign sat_mono = sat32(prod_a_s1 >>> 16);
	assign sat_res = sat32(64'(acc_q));
	assign term_sh = prod_b_s3 >>> 16;

	// Loads only land while idle, so they never meet a term read.
	assign ram_we = accept_in && (cmd == CMD_LOAD) && (int'(coef_index) < STORE_DEPTH);
	assign ram_waddr = AW'(coef_index);
	assign ram_re = (state_q == ST_TERM);

	bpe_ram #(
		.WIDTH(COEF_W),
		.DEPTH(STORE_DEPTH)
	) u_coef_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(coef_value),
		.re(ram_re),
		.raddr(i_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			deg_q <= DEG_W'(2);
			k_q <= '0;
			d_q <= '0;
			dx_q <= '0;
			i_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				deg_q <= degree;
			end
			case (state_q)
				ST_IDLE: begin
					if (eval_go) begin
						k_q <= PW_W'(1);
						d_q <= deg_use;
						dx_q <= deg_use;
						i_q <= '0;
						state_q <= (deg_use == '0) ? ST_TERM : ST_POW_MUL;
					end
				end
				ST_POW_MUL: begin
					state_q <= ST_POW_WB;
				end
				ST_POW_WB: begin
					if (k_q == deg_use) begin
						state_q <= ST_TERM;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= ST_POW_MUL;
					end
				end
				ST_TERM: begin
					i_q <= i_q + 1'b1;
					if (last_term) begin
						state_q <= ST_DRAIN;
					end else if (dx_q == '0) begin
						d_q <= d_q - 1'b1;
						dx_q <= d_q - 1'b1;
					end else begin
						dx_q <= dx_q - 1'b1;
					end
				end
				ST_DRAIN: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			v_s1 <= (state_q == ST_TERM);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (eval_go) begin
			x_q <= x_coord;
			y_q <= y_coord;
			px_q[0] <= ONE_Q16;
			py_q[0] <= ONE_Q16;
		end
		if (state_q == ST_POW_MUL || state_q == ST_TERM) begin
			prod_a_s1 <= mul_a;
		end
		if (state_q == ST_POW_WB) begin
			px_q[k_q] <= sat_px.val;
			py_q[k_q] <= sat_py.val;
		end
		if (v_s1) begin
			mono_s2 <= sat_mono.val;
			coef_s2 <= signed'(ram_rdata);
		end
		if (pow_phase || v_s2) begin
			prod_b_s3 <= mul_b;
		end
		if (eval_go) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= acc_q + signed'(term_sh[ACC_W-1:0]);
		end
		// Any clip along the way, powers or monomials, marks the result.
		if (eval_go) begin
			clip_q <= 1'b0;
		end else begin
			clip_q <= clip_q
				| ((state_q == ST_POW_WB) && (sat_px.clip || sat_py.clip))
				| (v_s1 && sat_mono.clip);
		end
		if (emit) begin
			poly_value_q <= sat_res.val;
			saturated_q <= clip_q | sat_res.clip;
		end
	end

	assign out_valid = out_valid_q;
	assign poly_value = poly_value_q;
	assign saturated = saturated_q;

endmodule

@@ src/bpe_chk.sv @@
`include "bivariate_poly_eval_top_defines.svh"

module bpe_chk
	import bpe_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic cmd,
	input logic out_valid,
	input logic out_ready,
	input logic signed [31:0] poly_value,
	input logic saturated
);

	// A stalled result holds.
	`BPE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(poly_value) && $stable(saturated))
	// An evaluation closes the input side for at least the next cycle.
	`BPE_ASSERT_NEXT(a_eval_busy, in_valid && in_ready && cmd == CMD_EVAL, !in_ready)
	// A load leaves the input side open in the next cycle.
	`BPE_ASSERT_NEXT(a_load_quick, in_valid && in_ready && cmd == CMD_LOAD, in_ready)
	// A new result appears only as an evaluation ends and the input reopens.
	`BPE_ASSERT_IMPL(a_out_from_busy, $rose(out_valid), in_ready && $past(!in_ready))

endmodule

bind bivariate_poly_eval_top bpe_chk u_bpe_chk (.*);

@@ tb/bivariate_poly_eval_top_test.sv @@
`timescale 1ns / 1ps

module bivariate_poly_eval_top_test;
	import bpe_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 100;

	typedef struct packed {
		logic signed [31:0] value;
		logic clip;
	} poly_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = CMD_LOAD;
	logic [IDX_W-1:0] coef_index = '0;
	logic signed [COEF_W-1:0] coef_value = '0;
	logic signed [CRD_W-1:0] x_coord = '0;
	logic signed [CRD_W-1:0] y_coord = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] poly_value;
	logic saturated;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [DEG_W-1:0] degree = 3'd2;

	// predictor state
	logic signed [COEF_W-1:0] coef_model [STORE_DEPTH];
	logic [DEG_W-1:0] cur_degree = 3'd2;
	poly_result_t expected_values [$];
	poly_result_t exp_r;

	bit steady = 1'b0;
	int hold_request = 0;
	int hold_left = 0;
	int cycles = 0;
	int mismatch_count = 0;
	int n_loads = 0;
	int n_evals = 0;
	int n_results = 0;
	int n_clipped = 0;

	bivariate_poly_eval_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.coef_index(coef_index),
		.coef_value(coef_value),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.poly_value(poly_value),
		.saturated(saturated),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.degree(degree)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint clamp32(input longint v, inout bit clip);
		longint hi;
		longint lo;
		hi = 2147483647;
		lo = -hi - 1;
		if (v > hi) begin
			clip = 1'b1;
			return hi;
		end
		if (v < lo) begin
			clip = 1'b1;
			return lo;
		end
		return v;
	endfunction

	function automatic poly_result_t eval_poly(input logic signed [CRD_W-1:0] xv,
			input logic signed [CRD_W-1:0] yv);
		longint px [MAX_DEGREE+1];
		longint py [MAX_DEGREE+1];
		longint acc;
		longint m;
		bit clip;
		int deg;
		int d;
		int dx;
		int k;
		int i;
		poly_result_t r;
		clip = 1'b0;
		deg = (int'(cur_degree) > MAX_DEGREE) ? MAX_DEGREE : int'(cur_degree);
		px[0] = longint'(ONE_Q16);
		py[0] = longint'(ONE_Q16);
		for (k = 1; k <= deg; k++) begin
			px[k] = clamp32((px[k-1] * longint'(xv)) >>> 8, clip);
			py[k] = clamp32((py[k-1] * longint'(yv)) >>> 8, clip);
		end
		acc = 0;
		i = 0;
		for (d = deg; d >= 0; d--) begin
			for (dx = d; dx >= 0; dx--) begin
				m = clamp32((px[dx] * py[d-dx]) >>> 16, clip);
				acc += (longint'(coef_model[i]) * m) >>> 16;
				i++;
			end
		end
		r.value = 32'(clamp32(acc, clip));
		r.clip = clip;
		return r;
	endfunction

	function automatic logic signed [CRD_W-1:0] rand_coord();
		case ($urandom_range(3))
			0, 1: return CRD_W'(int'($urandom_range(1024)) - 512);
			2: return CRD_W'(int'($urandom_range(16384)) - 8192);
			default: return CRD_W'($urandom());
		endcase
	endfunction

	function automatic logic signed [COEF_W-1:0] rand_coef();
		if ($urandom_range(1))
			return $urandom();
		return int'($urandom_range(1 << 19)) - (1 << 18);
	endfunction

	task automatic send_item(input logic c, input logic [IDX_W-1:0] idx,
			input logic signed [COEF_W-1:0] cv, input logic signed [CRD_W-1:0] xv,
			input logic signed [CRD_W-1:0] yv);
		while (!steady && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		coef_index <= idx;
		coef_value <= cv;
		x_coord <= xv;
		y_coord <= yv;
		do @(posedge clk); while (!in_ready);
		if (c == CMD_LOAD) begin
			n_loads++;
			if (idx < STORE_DEPTH)
				coef_model[idx] = cv;
		end else begin
			n_evals++;
			expected_values.push_back(eval_poly(xv, yv));
		end
	endtask

	task automatic send_eval(input logic signed [CRD_W-1:0] xv,
			input logic signed [CRD_W-1:0] yv);
		send_item(CMD_EVAL, IDX_W'($urandom()), $urandom(), xv, yv);
	endtask

	task automatic send_random_item();
		if ($urandom_range(99) < 35)
			send_item(CMD_LOAD, IDX_W'($urandom_range(15)), rand_coef(),
				CRD_W'($urandom()), CRD_W'($urandom()));
		else
			send_eval(rand_coord(), rand_coord());
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_values.size() != 0)
			@(posedge clk);
		// a trailing load has no result; give the pipe time to settle
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_degree(input logic [DEG_W-1:0] d);
		wait_idle();
		cfg_valid <= 1'b1;
		degree <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_degree = d;
	endtask

	task automatic test_coef_load_and_default_degree();
		int i;
		logic signed [COEF_W-1:0] cv;
		for (i = 0; i < STORE_DEPTH; i++) begin
			case (i)
				0: cv = 32'sh7fff_ffff;
				1: cv = 32'sh8000_0000;
				2: cv = ONE_Q16;
				3: cv = -ONE_Q16;
				default: cv = rand_coef();
			endcase
			send_item(CMD_LOAD, IDX_W'(i), cv, CRD_W'($urandom()), CRD_W'($urandom()));
		end
		// out-of-range index must leave the store alone
		send_item(CMD_LOAD, 4'd15, 32'sh5a5a_a5a5, 16'sh7fff, 16'sh8000);
		send_eval(16'sh0000, 16'sh0000);
		send_eval(16'sh0100, 16'sh0100);
		send_eval(16'sh7fff, 16'sh8000);
		send_eval(16'sh8000, 16'sh8000);
		send_eval(16'sh5555, 16'shaaaa);
	endtask

	task automatic test_degree_extremes();
		int d;
		for (d = 0; d < 8; d++) begin
			set_degree(DEG_W'(d));
			send_eval(16'sh7fff, 16'sh7fff);
			send_eval(-16'sh0100, 16'sh0100);
			send_eval(rand_coord(), rand_coord());
			send_eval(rand_coord(), rand_coord());
		end
	endtask

	task automatic test_random_mix();
		int phase;
		int n;
		for (phase = 0; phase < 6; phase++) begin
			set_degree(DEG_W'($urandom_range(7)));
			steady = (phase == 3);
			for (n = 0; n < PHASE_ITEMS; n++)
				send_random_item();
			steady = 1'b0;
		end
	endtask

	task automatic test_output_backpressure();
		int n;
		set_degree(3'd4);
		hold_request = HOLD_CYCLES;
		steady = 1'b1;
		for (n = 0; n < 40; n++)
			send_eval(rand_coord(), rand_coord());
		steady = 1'b0;
	endtask

	// receiver: random stalls, plus one long hold when requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady || ($urandom_range(99) >= 27);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (expected_values.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: poly_value=%h saturated=%b",
						poly_value, saturated);
			end else begin
				exp_r = expected_values.pop_front();
				if (exp_r.clip)
					n_clipped++;
				if (poly_value !== exp_r.value || saturated !== exp_r.clip) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %h/%b, got %h/%b",
							exp_r.value, exp_r.clip, poly_value, saturated);
				end
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("[bivariate_poly_eval_top] ERROR");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_coef_load_and_default_degree();
		test_degree_extremes();
		test_random_mix();
		test_output_backpressure();
		wait_idle();
		if (expected_values.size() != 0)
			mismatch_count += expected_values.size();
		$display("covered %0d coefficient loads and %0d evaluations over degrees 0..7",
			n_loads, n_evals);
		$display("%0d results checked, %0d with clipping, %0d mismatches",
			n_results, n_clipped, mismatch_count);
		if (mismatch_count == 0)
			$display("[bivariate_poly_eval_top] OK");
		else
			$display("[bivariate_poly_eval_top] ERROR");
		$finish;
	end

endmodule
